### hdl/rbbw_pkg.sv
// Shared constants, status codes and types of the red blob bounding box watch.
// Used by the channel interfaces and all modules; depends on nothing.
package rbbw_pkg;

    // Field widths
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 9;
    localparam int CNT_W   = 17;
    localparam int RATIO_W = 10;
    localparam int MARGIN_W = 8;
    localparam int STATUS_W = 4;
    localparam int PROD_W  = RATIO_W + COLOR_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RED_RATIO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TOL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 3'd3;

    // Register reset values
    localparam logic [RATIO_W-1:0]  RATIO_RST   = 10'd435;
    localparam logic [MARGIN_W-1:0] MARGIN_RST  = 8'd25;
    localparam logic [CNT_W-1:0]    TOL_RST     = 17'd500;
    localparam logic [CNT_W-1:0]    MIN_CNT_RST = 17'd2000;

    // Frame geometry
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam logic [COL_W-1:0] BOX_RIGHT_FULL = COL_W'(FRAME_WIDTH);
    localparam logic [ROW_W-1:0] BOX_BOTTOM_FULL = ROW_W'(FRAME_HEIGHT);
    localparam logic [COL_W:0]   FRAME_W_X = (COL_W + 1)'(FRAME_WIDTH);
    localparam logic [ROW_W:0]   FRAME_H_X = (ROW_W + 1)'(FRAME_HEIGHT);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FEW_RED    = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NEAR_EDGE  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_REF_STORED = 4'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_TOP        = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BOTTOM     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_LEFT       = 4'd6;
    localparam logic [STATUS_W-1:0] ST_RIGHT      = 4'd7;
    localparam logic [STATUS_W-1:0] ST_COUNT_HIGH = 4'd8;
    localparam logic [STATUS_W-1:0] ST_COUNT_LOW  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_NONE       = 4'd10;

    // Configuration register set
    typedef struct packed {
        logic [RATIO_W-1:0]  red_ratio_q8;
        logic [MARGIN_W-1:0] edge_margin;
        logic [CNT_W-1:0]    count_tolerance;
        logic [CNT_W-1:0]    min_red_count;
    } t_cfg;

    // Raw pixel word
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               frame_end;
    } t_pix;

    // Classified pixel word
    typedef struct packed {
        logic             is_red;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_end;
    } t_flag;

endpackage

### hdl/rbbw_pix_if.sv
// Pixel input channel: valid/ready handshake with one pixel word.
// Depends on rbbw_pkg.
interface rbbw_pix_if;
    import rbbw_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               frame_end;

    modport source (output valid, red, green, blue, row, col, frame_end, input ready);
    modport sink   (input valid, red, green, blue, row, col, frame_end, output ready);
endinterface

### hdl/rbbw_res_if.sv
// Result output channel: valid/ready handshake with one frame result word.
// Depends on rbbw_pkg.
interface rbbw_res_if;
    import rbbw_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    box_top;
    logic [ROW_W-1:0]    box_bottom;
    logic [COL_W-1:0]    box_left;
    logic [COL_W-1:0]    box_right;
    logic [CNT_W-1:0]    red_count;

    modport source (output valid, status, box_top, box_bottom, box_left, box_right,
                    red_count, input ready);
    modport sink   (input valid, status, box_top, box_bottom, box_left, box_right,
                    red_count, output ready);
endinterface

### hdl/rbbw_cfg_regs.sv
// Configuration register file: ratio, margin, count tolerance, minimum count.
// Depends on rbbw_pkg.
module rbbw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbbw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbbw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rbbw_pkg::t_cfg                  o_cfg
);
    import rbbw_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Write decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED_RATIO:   n_cfg.red_ratio_q8    = i_cfg_data[RATIO_W-1:0];
                CFG_EDGE_MARGIN: n_cfg.edge_margin     = i_cfg_data[MARGIN_W-1:0];
                CFG_COUNT_TOL:   n_cfg.count_tolerance = i_cfg_data[CNT_W-1:0];
                CFG_MIN_COUNT:   n_cfg.min_red_count   = i_cfg_data[CNT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_ratio_q8    <= RATIO_RST;
            r_cfg.edge_margin     <= MARGIN_RST;
            r_cfg.count_tolerance <= TOL_RST;
            r_cfg.min_red_count   <= MIN_CNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### hdl/rbbw_red_detect.sv
// Pixel input register and red classification stage (ratio multiply, compare).
// Depends on rbbw_pkg and rbbw_pix_if.
module rbbw_red_detect (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbbw_pkg::t_cfg i_cfg,
    rbbw_pix_if.sink       i_pix,
    output logic           o_flag_valid,
    output rbbw_pkg::t_flag o_flag,
    input  logic           i_flag_ready
);
    import rbbw_pkg::*;

    logic  r_s1_valid;
    t_pix  r_s1_pix;
    logic  r_s2_valid;
    t_flag r_s2_flag;

    logic              s1_take;
    logic              s2_take;
    logic              s1_move;
    logic [PROD_W-1:0] red_scaled;
    logic [PROD_W-1:0] prod_blue;
    logic [PROD_W-1:0] prod_green;
    t_flag             n_flag;

    // Stage handshakes: a stage loads when empty or when its word moves on
    assign s2_take = !r_s2_valid || i_flag_ready;
    assign s1_move = r_s1_valid && s2_take;
    assign s1_take = !r_s1_valid || s1_move;
    assign i_pix.ready = s1_take;

    // Red test: red*256 against ratio*blue and ratio*green
    always_comb begin
        red_scaled = {{(PROD_W - COLOR_W - 8){1'b0}}, r_s1_pix.red, 8'd0};
        prod_blue  = PROD_W'(i_cfg.red_ratio_q8) * PROD_W'(r_s1_pix.blue);
        prod_green = PROD_W'(i_cfg.red_ratio_q8) * PROD_W'(r_s1_pix.green);
        n_flag.is_red    = (red_scaled > prod_blue) && (red_scaled > prod_green);
        n_flag.row       = r_s1_pix.row;
        n_flag.col       = r_s1_pix.col;
        n_flag.frame_end = r_s1_pix.frame_end;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_take) r_s1_valid <= i_pix.valid;
            if (s2_take) r_s2_valid <= r_s1_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_take && i_pix.valid) begin
            r_s1_pix <= '{red: i_pix.red, green: i_pix.green, blue: i_pix.blue,
                          row: i_pix.row, col: i_pix.col, frame_end: i_pix.frame_end};
        end
        if (s1_move) r_s2_flag <= n_flag;
    end

    assign o_flag_valid = r_s2_valid;
    assign o_flag       = r_s2_flag;
endmodule

### hdl/rbbw_box_track.sv
// Running box and count, reference store, frame end checks, result register.
// Depends on rbbw_pkg and rbbw_res_if.
module rbbw_box_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rbbw_pkg::t_cfg  i_cfg,
    input  logic            i_flag_valid,
    input  rbbw_pkg::t_flag i_flag,
    output logic            o_flag_ready,
    rbbw_res_if.source      o_res
);
    import rbbw_pkg::*;

    // Running frame state
    logic [ROW_W-1:0] r_run_top,   n_run_top;
    logic [ROW_W-1:0] r_run_bottom, n_run_bottom;
    logic [COL_W-1:0] r_run_left,  n_run_left;
    logic [COL_W-1:0] r_run_right, n_run_right;
    logic [CNT_W-1:0] r_run_count, n_run_count;

    // Reference
    logic             r_ref_valid;
    logic [ROW_W-1:0] r_ref_top;
    logic [ROW_W-1:0] r_ref_bottom;
    logic [COL_W-1:0] r_ref_left;
    logic [COL_W-1:0] r_ref_right;
    logic [CNT_W-1:0] r_ref_count;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ROW_W-1:0]    r_out_top;
    logic [ROW_W-1:0]    r_out_bottom;
    logic [COL_W-1:0]    r_out_left;
    logic [COL_W-1:0]    r_out_right;
    logic [CNT_W-1:0]    r_out_count;

    logic                out_free;
    logic                fire;
    logic                frame_done;
    logic                store_ref;
    logic [ROW_W-1:0]    box_top;
    logic [ROW_W-1:0]    box_bottom;
    logic [COL_W-1:0]    box_left;
    logic [COL_W-1:0]    box_right;
    logic [STATUS_W-1:0] status;
    logic [MARGIN_W-1:0] m;
    logic [CNT_W:0]      cnt_x;
    logic [CNT_W:0]      tol_x;
    logic [CNT_W:0]      ref_cnt_x;

    // A frame end word needs the result register free; other words always pass
    assign out_free     = !r_out_valid || o_res.ready;
    assign o_flag_ready = !i_flag.frame_end || out_free;
    assign fire         = i_flag_valid && o_flag_ready;
    assign frame_done   = fire && i_flag.frame_end;

    // Running box update for the current pixel
    always_comb begin
        n_run_top    = r_run_top;
        n_run_bottom = r_run_bottom;
        n_run_left   = r_run_left;
        n_run_right  = r_run_right;
        n_run_count  = r_run_count;
        if (i_flag.is_red) begin
            if (r_run_count == '0) n_run_top = i_flag.row;
            n_run_bottom = i_flag.row;
            if (i_flag.col < r_run_left)  n_run_left  = i_flag.col;
            if (i_flag.col > r_run_right) n_run_right = i_flag.col;
            if (r_run_count != COUNT_MAX) n_run_count = r_run_count + 1'b1;
        end
    end

    // Frame box; no red gives the full screen
    always_comb begin
        if (n_run_count == '0) begin
            box_top    = '0;
            box_bottom = BOX_BOTTOM_FULL;
            box_left   = '0;
            box_right  = BOX_RIGHT_FULL;
        end else begin
            box_top    = n_run_top;
            box_bottom = n_run_bottom;
            box_left   = n_run_left;
            box_right  = n_run_right;
        end
    end

    // Frame end status: qualify a reference, or compare against it in order
    always_comb begin
        m         = i_cfg.edge_margin;
        cnt_x     = {1'b0, n_run_count};
        tol_x     = {1'b0, i_cfg.count_tolerance};
        ref_cnt_x = {1'b0, r_ref_count};
        store_ref = 1'b0;
        if (!r_ref_valid) begin
            if (n_run_count <= i_cfg.min_red_count) begin
                status = ST_FEW_RED;
            end else if ((COL_W'(m) > box_left)
                         || ({1'b0, box_right} + (COL_W + 1)'(m) > FRAME_W_X)
                         || (box_top < m)
                         || ({1'b0, box_bottom} + (ROW_W + 1)'(m) > FRAME_H_X)) begin
                status = ST_NEAR_EDGE;
            end else begin
                status    = ST_REF_STORED;
                store_ref = 1'b1;
            end
        end else begin
            if ({1'b0, box_top} > {1'b0, r_ref_top} + {1'b0, m}) begin
                status = ST_TOP;
            end else if ({1'b0, box_bottom} + {1'b0, m} < {1'b0, r_ref_bottom}) begin
                status = ST_BOTTOM;
            end else if ({1'b0, box_left} + (COL_W + 1)'(m) < {1'b0, r_ref_left}) begin
                status = ST_LEFT;
            end else if ({1'b0, box_right} > {1'b0, r_ref_right} + (COL_W + 1)'(m)) begin
                status = ST_RIGHT;
            end else if (cnt_x > ref_cnt_x + tol_x) begin
                status = ST_COUNT_HIGH;
            end else if (cnt_x + tol_x < ref_cnt_x) begin
                status = ST_COUNT_LOW;
            end else if (n_run_count == '0) begin
                status = ST_NONE;
            end else begin
                status = ST_PRESENT;
            end
        end
    end

    // Control state: running box, reference flag, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_top   <= '0;
            r_run_bottom <= '0;
            r_run_left  <= BOX_RIGHT_FULL;
            r_run_right <= '0;
            r_run_count <= '0;
            r_ref_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (frame_done) begin
                r_run_top   <= '0;
                r_run_bottom <= '0;
                r_run_left  <= BOX_RIGHT_FULL;
                r_run_right <= '0;
                r_run_count <= '0;
            end else if (fire) begin
                r_run_top   <= n_run_top;
                r_run_bottom <= n_run_bottom;
                r_run_left  <= n_run_left;
                r_run_right <= n_run_right;
                r_run_count <= n_run_count;
            end
            if (frame_done && store_ref) r_ref_valid <= 1'b1;
            if (frame_done)        r_out_valid <= 1'b1;
            else if (o_res.ready)  r_out_valid <= 1'b0;
        end
    end

    // Reference and result payload
    always_ff @(posedge i_clk) begin
        if (frame_done && store_ref) begin
            r_ref_top    <= box_top;
            r_ref_bottom <= box_bottom;
            r_ref_left   <= box_left;
            r_ref_right  <= box_right;
            r_ref_count  <= n_run_count;
        end
        if (frame_done) begin
            r_out_status <= status;
            r_out_top    <= box_top;
            r_out_bottom <= box_bottom;
            r_out_left   <= box_left;
            r_out_right  <= box_right;
            r_out_count  <= n_run_count;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.box_top    = r_out_top;
    assign o_res.box_bottom = r_out_bottom;
    assign o_res.box_left   = r_out_left;
    assign o_res.box_right  = r_out_right;
    assign o_res.red_count  = r_out_count;

`ifndef NO_ASSERTIONS
    // Once held, the reference is never dropped
    a_ref_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_valid |=> r_ref_valid)
        else $error("reference flag cleared");

    // Taking a reference always reports it
    a_ref_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ref_valid) |-> (r_out_valid && r_out_status == ST_REF_STORED))
        else $error("reference stored without its status word");

    // An empty frame keeps the cleared bounds
    a_empty_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_count == '0) |-> (r_run_left == BOX_RIGHT_FULL && r_run_right == '0))
        else $error("bounds moved without a red pixel");

    // With red seen, left never passes right
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_count != '0) |-> (r_run_left <= r_run_right))
        else $error("left bound beyond right bound");

    // A waiting word is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !frame_done)
        else $error("result register overwritten while stalled");
`endif
endmodule

### hdl/red_blob_bounding_box_watch_unit.sv
// Top level of the red blob bounding box watch: config registers, red detect,
// box tracking. Depends on rbbw_pkg, rbbw_pix_if, rbbw_res_if and submodules.
//
//   channel  | dir | word                                          | handshake
//   ---------+-----+-----------------------------------------------+----------
//   i_pix    | in  | red, green, blue, row, col, frame_end         | valid/ready
//   o_res    | out | status, box_top/bottom/left/right, red_count  | valid/ready
//   i_cfg_*  | in  | register index, write data                    | write enable
//
// One pixel is accepted per clock while the pipe is not stalled. A pixel passes an
// input register, a classify register (ratio multiply and compare) and the box
// update into the result register, which takes the frame result from its frame
// end pixel. The running box, count and reference update in one pass.
// Reset is synchronous and active low and restores the register defaults.
// Only a frame end pixel waits on a stalled result register; others flow on.
module red_blob_bounding_box_watch_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rbbw_pix_if.sink                        i_pix,
    rbbw_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [rbbw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbbw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rbbw_pkg::*;

    t_cfg  cfg;
    logic  flag_valid;
    logic  flag_ready;
    t_flag flag;

    rbbw_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rbbw_red_detect u_red_detect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pix        (i_pix),
        .o_flag_valid (flag_valid),
        .o_flag       (flag),
        .i_flag_ready (flag_ready)
    );

    rbbw_box_track u_box_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_flag_valid (flag_valid),
        .i_flag       (flag),
        .o_flag_ready (flag_ready),
        .o_res        (o_res)
    );
endmodule

### tb/tb_red_blob_bounding_box_watch_unit.sv
// Self-checking testbench of red_blob_bounding_box_watch_unit: pixel frames in,
// frame box results checked against a built-in box predictor held in a scoreboard.
// Depends on rbbw_pkg, rbbw_pix_if, rbbw_res_if and the block itself.
module tb_red_blob_bounding_box_watch_unit;
    import rbbw_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    // One frame result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROW_W-1:0]    top;
        logic [ROW_W-1:0]    bottom;
        logic [COL_W-1:0]    left;
        logic [COL_W-1:0]    right;
        logic [CNT_W-1:0]    count;
    } t_frame_res;

    // Box predictor plus the queue of frame results still due
    class box_watch_scoreboard;
        int ratio, margin, tol, min_cnt;
        int run_top, run_bottom, run_left, run_right, run_cnt;
        bit have_base;
        int base_top, base_bottom, base_left, base_right, base_cnt;
        t_frame_res frames_due[$];
        int mismatches;

        function new();
            ratio     = int'(RATIO_RST);
            margin    = int'(MARGIN_RST);
            tol       = int'(TOL_RST);
            min_cnt   = int'(MIN_CNT_RST);
            have_base = 1'b0;
            base_top = 0; base_bottom = 0; base_left = 0; base_right = 0; base_cnt = 0;
            mismatches = 0;
            clear_box();
        endfunction

        function void clear_box();
            run_top    = 0;
            run_bottom = 0;
            run_left   = FRAME_WIDTH;
            run_right  = 0;
            run_cnt    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RED_RATIO:   ratio   = int'(data[RATIO_W-1:0]);
                CFG_EDGE_MARGIN: margin  = int'(data[MARGIN_W-1:0]);
                CFG_COUNT_TOL:   tol     = int'(data);
                CFG_MIN_COUNT:   min_cnt = int'(data);
                default: ;
            endcase
        endfunction

        // Track the running box; on a frame end word, predict the result
        function void note_pixel(t_pix p);
            int top, bottom, left, right;
            logic [STATUS_W-1:0] st;
            t_frame_res e;
            if (int'(p.red) * 256 > ratio * int'(p.blue) &&
                int'(p.red) * 256 > ratio * int'(p.green)) begin
                if (run_cnt == 0) run_top = int'(p.row);
                run_bottom = int'(p.row);
                if (int'(p.col) < run_left) run_left = int'(p.col);
                if (int'(p.col) > run_right) run_right = int'(p.col);
                if (run_cnt < int'(COUNT_MAX)) run_cnt++;
            end
            if (!p.frame_end) return;

            // no red at all reports the full screen
            if (run_cnt == 0) begin
                top = 0; bottom = FRAME_HEIGHT; left = 0; right = FRAME_WIDTH;
            end else begin
                top = run_top; bottom = run_bottom; left = run_left; right = run_right;
            end

            if (!have_base) begin
                if (run_cnt <= min_cnt) begin
                    st = ST_FEW_RED;
                end else if (left - margin < 0 || right + margin > FRAME_WIDTH ||
                             top - margin < 0 || bottom + margin > FRAME_HEIGHT) begin
                    st = ST_NEAR_EDGE;
                end else begin
                    have_base   = 1'b1;
                    base_top    = top;
                    base_bottom = bottom;
                    base_left   = left;
                    base_right  = right;
                    base_cnt    = run_cnt;
                    st = ST_REF_STORED;
                end
            end else begin
                // first failing check wins
                if (top > base_top + margin)             st = ST_TOP;
                else if (bottom < base_bottom - margin)  st = ST_BOTTOM;
                else if (left < base_left - margin)      st = ST_LEFT;
                else if (right > base_right + margin)    st = ST_RIGHT;
                else if (run_cnt > base_cnt + tol)       st = ST_COUNT_HIGH;
                else if (run_cnt < base_cnt - tol)       st = ST_COUNT_LOW;
                else if (run_cnt == 0)                   st = ST_NONE;
                else                                     st = ST_PRESENT;
            end

            e.status = st;
            e.top    = top[ROW_W-1:0];
            e.bottom = bottom[ROW_W-1:0];
            e.left   = left[COL_W-1:0];
            e.right  = right[COL_W-1:0];
            e.count  = run_cnt[CNT_W-1:0];
            frames_due.push_back(e);
            clear_box();
        endfunction

        function void check_frame(t_frame_res got);
            t_frame_res want;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with none due: st %0d box %0d %0d %0d %0d cnt %0d",
                             got.status, got.top, got.bottom, got.left, got.right, got.count);
                return;
            end
            want = frames_due.pop_front();
            if (got.status !== want.status || got.top !== want.top ||
                got.bottom !== want.bottom || got.left !== want.left ||
                got.right !== want.right || got.count !== want.count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: st %0d box %0d %0d %0d %0d cnt %0d",
                             want.status, want.top, want.bottom, want.left, want.right,
                             want.count);
                    $display("         act: st %0d box %0d %0d %0d %0d cnt %0d",
                             got.status, got.top, got.bottom, got.left, got.right,
                             got.count);
                end
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rbbw_pix_if pix_if ();
    rbbw_res_if res_if ();

    red_blob_bounding_box_watch_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    box_watch_scoreboard sb;
    int         cycles = 0;
    int         items_sent = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;
    t_frame_res seen;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int source_gap();
        if (quiet || $urandom_range(0, 99) < 55) return 0;
        return idle_len();
    endfunction

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len() - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen.status = res_if.status;
            seen.top    = res_if.box_top;
            seen.bottom = res_if.box_bottom;
            seen.left   = res_if.box_left;
            seen.right  = res_if.box_right;
            seen.count  = res_if.red_count;
            sb.check_frame(seen);
        end
    end

    function automatic t_pix pixel_word(int r, int g, int b, int row, int col, bit fe);
        t_pix p;
        p.red       = r[COLOR_W-1:0];
        p.green     = g[COLOR_W-1:0];
        p.blue      = b[COLOR_W-1:0];
        p.row       = row[ROW_W-1:0];
        p.col       = col[COL_W-1:0];
        p.frame_end = fe;
        return p;
    endfunction

    // Random pixel: red-ish words near the stored box, plus noise
    function automatic t_pix make_pixel(bit last, bit noisy);
        t_pix p;
        int k;
        k = $urandom_range(0, 99);
        if (noisy) begin
            p = pixel_word($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 511), last || $urandom_range(0, 9) == 0);
            return p;
        end
        if (k < 50) begin
            p.red   = COLOR_W'($urandom_range(128, 255));
            p.green = COLOR_W'($urandom_range(0, p.red / 2));
            p.blue  = COLOR_W'($urandom_range(0, p.red / 2));
        end else if (k < 75) begin
            p.red   = COLOR_W'($urandom_range(0, 255));
            p.green = COLOR_W'($urandom_range(0, 255));
            p.blue  = COLOR_W'($urandom_range(0, 255));
        end else begin
            p.red   = COLOR_W'($urandom_range(0, 120));
            p.green = COLOR_W'($urandom_range(100, 255));
            p.blue  = COLOR_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
            p.row = ROW_W'($urandom_range(0, 255));
            p.col = COL_W'($urandom_range(0, 511));
        end else begin
            p.row = ROW_W'($urandom_range(92, 148));
            p.col = COL_W'($urandom_range(92, 208));
        end
        p.frame_end = last;
        return p;
    endfunction

    // Offer one pixel word, hold it until taken, then maybe idle
    task automatic send_pixel(input t_pix p, input int gap);
        pix_if.valid     <= 1'b1;
        pix_if.red       <= p.red;
        pix_if.green     <= p.green;
        pix_if.blue      <= p.blue;
        pix_if.row       <= p.row;
        pix_if.col       <= p.col;
        pix_if.frame_end <= p.frame_end;
        do begin
            @(posedge i_clk);
        end while (!pix_if.ready);
        sb.note_pixel(p);
        items_sent++;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int len, input bit noisy);
        for (int i = 0; i < len; i++)
            send_pixel(make_pixel(i == len - 1, noisy), source_gap());
    endtask

    // Wait until every due frame result has come, then let the pipe empty
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic set_regs(input int ratio, input int margin, input int tol,
                            input int min_cnt, input bit poke_spare);
        write_cfg(CFG_RED_RATIO, ratio);
        write_cfg(CFG_EDGE_MARGIN, margin);
        write_cfg(CFG_COUNT_TOL, tol);
        write_cfg(CFG_MIN_COUNT, min_cnt);
        // unmapped index must leave every register alone
        if (poke_spare) write_cfg(CFG_SPARE_IDX, $urandom_range(0, 131071));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int start;
        int len;
        int k;
        sb = new();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        pix_if.valid     <= 1'b0;
        pix_if.red       <= '0;
        pix_if.green     <= '0;
        pix_if.blue      <= '0;
        pix_if.row       <= '0;
        pix_if.col       <= '0;
        pix_if.frame_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: too few red, then an empty frame with the full box
        send_pixel(pixel_word(255, 0, 0, 239, 319, 1), source_gap());
        send_pixel(pixel_word(0, 0, 0, 0, 0, 1), source_gap());
        drain();

        // No minimum: a frame on the top edge, then one stored as the base box
        set_regs(int'(RATIO_RST), 25, int'(TOL_RST), 0, 1'b0);
        send_pixel(pixel_word(255, 0, 0, 0, 100, 1), source_gap());
        send_pixel(pixel_word(255, 149, 149, 100, 100, 0), source_gap());
        send_pixel(pixel_word(255, 151, 0, 255, 511, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 120, 150, 0), source_gap());
        send_pixel(pixel_word(200, 10, 20, 140, 200, 1), source_gap());
        drain();

        // Each failing check against the base box, then a match
        set_regs(int'(RATIO_RST), 10, 0, 0, 1'b0);
        send_pixel(pixel_word(255, 0, 0, 120, 150, 1), source_gap());
        send_pixel(pixel_word(255, 0, 0, 100, 150, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 100, 150, 1), source_gap());
        send_pixel(pixel_word(255, 0, 0, 100, 50, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 140, 150, 1), source_gap());
        send_pixel(pixel_word(255, 0, 0, 100, 100, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 140, 255, 1), source_gap());
        repeat (3) send_pixel(pixel_word(255, 0, 0, 100, 100, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 140, 200, 1), source_gap());
        send_pixel(pixel_word(255, 0, 0, 100, 100, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 140, 200, 1), source_gap());
        send_pixel(pixel_word(255, 0, 0, 100, 100, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 120, 150, 0), source_gap());
        send_pixel(pixel_word(255, 0, 0, 140, 200, 1), source_gap());
        drain();

        // Wide limits: an empty frame passes every check
        set_regs(int'(RATIO_RST), 255, 76800, 0, 1'b0);
        send_pixel(pixel_word(0, 255, 255, 255, 511, 1), source_gap());
        drain();

        // Random frames over a range of settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 6)
                0: set_regs(0, 0, 0, 0, 1'b0);
                1: set_regs(1023, 255, 76800, 76800, 1'b1);
                2: set_regs(int'(RATIO_RST), $urandom_range(0, 30), $urandom_range(0, 6),
                            $urandom_range(0, 10), 1'b0);
                3: set_regs($urandom_range(256, 700), $urandom_range(5, 40),
                            $urandom_range(0, 4), $urandom_range(0, 76800), 1'b0);
                4: set_regs($urandom_range(0, 1023), $urandom_range(0, 255),
                            $urandom_range(0, 76800), $urandom_range(0, 76800), 1'b1);
                default: set_regs(int'(RATIO_RST), int'(MARGIN_RST), int'(TOL_RST),
                                  int'(MIN_CNT_RST), 1'b0);
            endcase
            quiet = (ph % 4 == 3);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                k = $urandom_range(0, 99);
                if (k < 80)      len = $urandom_range(1, 12);
                else if (k < 95) len = $urandom_range(13, 30);
                else             len = $urandom_range(31, 60);
                send_frame(len, $urandom_range(0, 9) == 0);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### red_blob_bounding_box_watch_unit.f
hdl/rbbw_pkg.sv
hdl/rbbw_pix_if.sv
hdl/rbbw_res_if.sv
hdl/rbbw_cfg_regs.sv
hdl/rbbw_red_detect.sv
hdl/rbbw_box_track.sv
hdl/red_blob_bounding_box_watch_unit.sv
tb/tb_red_blob_bounding_box_watch_unit.sv
